[rtl/fha_pkg.sv]
// ----------------------------------------------------------------------------
// fha_pkg
// shared widths, codes and control types of the fit hole allocator
// ----------------------------------------------------------------------------
package fha_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned SIZE_W  = 16;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned TOTAL_W = 21;
  localparam int unsigned MODE_W  = 2;

  // opcodes
  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_LOADED    = 3'd0;
  localparam logic [STAT_W-1:0] ST_GRANTED   = 3'd1;
  localparam logic [STAT_W-1:0] ST_NO_FIT    = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STAT_W-1:0] ST_RESTARTED = 3'd4;

  // placement policies, anything else acts as first fit
  localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

  typedef struct packed {
    logic start;   // latch accepted word, restart the scan
    logic scan;    // read next slot and advance
    logic commit;  // update state and write the result word
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] in_op;
    logic            empty;
    logic            scan_last;
    logic            out_free;
  } sts_t;

endpackage

[rtl/fha_if.sv]
// ----------------------------------------------------------------------------
// fha_if
// valid/ready channels for input words and result words
// ----------------------------------------------------------------------------
interface fha_in_if;
  logic                          valid;
  logic                          ready;
  logic [fha_pkg::OP_W-1:0]      opcode;
  logic [fha_pkg::SIZE_W-1:0]    item_size;

  modport source (output valid, output opcode, output item_size, input ready);
  modport sink   (input valid, input opcode, input item_size, output ready);
endinterface

interface fha_out_if;
  logic                          valid;
  logic                          ready;
  logic [fha_pkg::STAT_W-1:0]    status;
  logic [fha_pkg::IDX_W-1:0]     hole_index;
  logic [fha_pkg::SIZE_W-1:0]    granted_hole_size;
  logic [fha_pkg::TOTAL_W-1:0]   internal_frag_total;
  logic [fha_pkg::TOTAL_W-1:0]   external_frag_total;

  modport source (output valid, output status, output hole_index,
                  output granted_hole_size, output internal_frag_total,
                  output external_frag_total, input ready);
  modport sink   (input valid, input status, input hole_index,
                  input granted_hole_size, input internal_frag_total,
                  input external_frag_total, output ready);
endinterface

[rtl/fit_hole_allocator.sv]
// ----------------------------------------------------------------------------
// fit_hole_allocator
// first, best and worst fit allocator over a table of loaded hole sizes
// ----------------------------------------------------------------------------
// load and restart: idle, then done, where the result is committed once the
//   result slot frees; unknown opcodes are dropped in idle with no result
// allocate: idle, then the scan that reads one hole slot per cycle from the
//   hole ram, then drain and done; on an empty table straight to done
// one word at a time; the next word is accepted while a result is still held
// reset clears marks, count, totals and fit_mode; the hole ram needs no clear
// ----------------------------------------------------------------------------
module fit_hole_allocator #(
  parameter int unsigned MAX_HOLES = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [fha_pkg::MODE_W-1:0]  cfg_wdata_i,
  fha_in_if.sink                      in_i,
  fha_out_if.source                   out_o
);

  // command and status between sequencer and datapath
  fha_pkg::cmd_t cmd;
  fha_pkg::sts_t sts;
  logic          in_ready;

  // sequencer: idle -> (scan -> drain) -> done, commit when result slot frees
  fha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // hole ram, used marks, running candidate and fragmentation totals
  fha_datapath #(
    .MAX_HOLES (MAX_HOLES)
  ) u_datapath (
    .clk_i                     (clk_i),
    .rst_ni                    (rst_ni),
    .cfg_we_i                  (cfg_we_i),
    .cfg_wdata_i               (cfg_wdata_i),
    .in_opcode_i               (in_i.opcode),
    .in_item_size_i            (in_i.item_size),
    .out_ready_i               (out_o.ready),
    .out_valid_o               (out_o.valid),
    .out_status_o              (out_o.status),
    .out_hole_index_o          (out_o.hole_index),
    .out_granted_hole_size_o   (out_o.granted_hole_size),
    .out_internal_frag_total_o (out_o.internal_frag_total),
    .out_external_frag_total_o (out_o.external_frag_total),
    .cmd_i                     (cmd),
    .sts_o                     (sts)
  );

  // ready whenever the sequencer is idle, even with a result word pending
  assign in_i.ready = in_ready;

endmodule

[rtl/fha_ram.sv]
// ----------------------------------------------------------------------------
// fha_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module fha_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/fha_ctrl.sv]
// ----------------------------------------------------------------------------
// fha_ctrl
// sequencer: accept, scan hole slots, commit result
// ----------------------------------------------------------------------------
module fha_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output fha_pkg::cmd_t cmd_o,
  input  fha_pkg::sts_t sts_i
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          unique case (sts_i.in_op)
            fha_pkg::OP_LOAD,
            fha_pkg::OP_RESTART: state_d = S_DONE;
            fha_pkg::OP_ALLOC:   state_d = sts_i.empty ? S_DONE : S_SCAN;
            default:             state_d = S_IDLE;  // unknown opcode, dropped
          endcase
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last read data is evaluated here
        state_d = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/fha_datapath.sv]
// ----------------------------------------------------------------------------
// fha_datapath
// hole table, used marks, candidate tracking, totals and result register
// ----------------------------------------------------------------------------
module fha_datapath #(
  parameter int unsigned MAX_HOLES = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fha_pkg::MODE_W-1:0]     cfg_wdata_i,
  input  logic [fha_pkg::OP_W-1:0]       in_opcode_i,
  input  logic [fha_pkg::SIZE_W-1:0]     in_item_size_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [fha_pkg::STAT_W-1:0]     out_status_o,
  output logic [fha_pkg::IDX_W-1:0]      out_hole_index_o,
  output logic [fha_pkg::SIZE_W-1:0]     out_granted_hole_size_o,
  output logic [fha_pkg::TOTAL_W-1:0]    out_internal_frag_total_o,
  output logic [fha_pkg::TOTAL_W-1:0]    out_external_frag_total_o,
  input  fha_pkg::cmd_t                  cmd_i,
  output fha_pkg::sts_t                  sts_o
);

  localparam int unsigned IW = $clog2(MAX_HOLES);
  localparam int unsigned CW = $clog2(MAX_HOLES + 1);
  localparam int unsigned SW = fha_pkg::SIZE_W;
  localparam int unsigned TW = fha_pkg::TOTAL_W;
  localparam int unsigned XW = IW + fha_pkg::IDX_W;

  // control state
  logic [fha_pkg::MODE_W-1:0] fit_mode_q, fit_mode_d;
  logic [CW-1:0]              loaded_q, loaded_d;
  logic [IW-1:0]              scan_idx_q, scan_idx_d;
  logic                       rd_valid_q, rd_valid_d;
  logic                       found_q, found_d;
  logic [MAX_HOLES-1:0]       used_q, used_d;
  logic [TW-1:0]              internal_q, internal_d;
  logic [TW-1:0]              free_q, free_d;
  logic [TW-1:0]              loaded_sum_q, loaded_sum_d;
  logic                       out_valid_q, out_valid_d;

  // payload
  logic [fha_pkg::OP_W-1:0]   op_q, op_d;
  logic [SW-1:0]              req_q, req_d;
  logic [IW-1:0]              rd_idx_q, rd_idx_d;
  logic [IW-1:0]              best_idx_q, best_idx_d;
  logic [SW-1:0]              best_size_q, best_size_d;
  logic [fha_pkg::STAT_W-1:0] status_q, status_d;
  logic [fha_pkg::IDX_W-1:0]  index_q, index_d;
  logic [SW-1:0]              granted_q, granted_d;

  logic [SW-1:0] rd_data;
  logic          full;
  logic          grant;
  logic          take;
  logic          slot_free;
  logic          fits;
  logic          ram_we;
  logic [XW-1:0] load_idx_ext;
  logic [XW-1:0] best_idx_ext;

  fha_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_HOLES)
  ) u_hole_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (loaded_q[IW-1:0]),
    .wdata_i (req_q),
    .raddr_i (scan_idx_q),
    .rdata_o (rd_data)
  );

  assign full         = (loaded_q == CW'(MAX_HOLES));
  assign grant        = found_q && (best_size_q >= req_q);
  assign ram_we       = cmd_i.commit && (op_q == fha_pkg::OP_LOAD) && !full;
  assign load_idx_ext = {{fha_pkg::IDX_W{1'b0}}, loaded_q[IW-1:0]};
  assign best_idx_ext = {{fha_pkg::IDX_W{1'b0}}, best_idx_q};
  assign slot_free    = !used_q[rd_idx_q];
  assign fits         = (rd_data >= req_q);

  // candidate selection per policy, strict compares keep ties on the lower slot
  always_comb begin
    unique case (fit_mode_q)
      fha_pkg::MODE_WORST: take = slot_free && (!found_q || rd_data > best_size_q);
      fha_pkg::MODE_BEST:  take = slot_free && fits && (!found_q || rd_data < best_size_q);
      default:             take = slot_free && fits && !found_q;
    endcase
  end

  always_comb begin
    fit_mode_d   = fit_mode_q;
    loaded_d     = loaded_q;
    scan_idx_d   = scan_idx_q;
    rd_valid_d   = cmd_i.scan;
    found_d      = found_q;
    used_d       = used_q;
    internal_d   = internal_q;
    free_d       = free_q;
    loaded_sum_d = loaded_sum_q;
    op_d         = op_q;
    req_d        = req_q;
    rd_idx_d     = scan_idx_q;
    best_idx_d   = best_idx_q;
    best_size_d  = best_size_q;
    status_d     = status_q;
    index_d      = index_q;
    granted_d    = granted_q;

    if (cfg_we_i) begin
      fit_mode_d = cfg_wdata_i;
    end

    if (cmd_i.start) begin
      op_d       = in_opcode_i;
      req_d      = in_item_size_i;
      scan_idx_d = '0;
      found_d    = 1'b0;
    end

    if (cmd_i.scan) begin
      scan_idx_d = scan_idx_q + IW'(1);
    end

    if (rd_valid_q && take) begin
      found_d     = 1'b1;
      best_idx_d  = rd_idx_q;
      best_size_d = rd_data;
    end

    if (cmd_i.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end

    if (cmd_i.commit) begin
      index_d   = '0;
      granted_d = '0;
      unique case (op_q)
        fha_pkg::OP_LOAD: begin
          if (full) begin
            status_d = fha_pkg::ST_FULL;
          end else begin
            status_d                  = fha_pkg::ST_LOADED;
            index_d                   = load_idx_ext[fha_pkg::IDX_W-1:0];
            used_d[loaded_q[IW-1:0]]  = 1'b0;
            loaded_d                  = loaded_q + CW'(1);
            free_d                    = free_q + TW'(req_q);
            loaded_sum_d              = loaded_sum_q + TW'(req_q);
          end
        end
        fha_pkg::OP_ALLOC: begin
          if (grant) begin
            status_d           = fha_pkg::ST_GRANTED;
            index_d            = best_idx_ext[fha_pkg::IDX_W-1:0];
            granted_d          = best_size_q;
            used_d[best_idx_q] = 1'b1;
            internal_d         = internal_q + (TW'(best_size_q) - TW'(req_q));
            free_d             = free_q - TW'(best_size_q);
          end else begin
            status_d = fha_pkg::ST_NO_FIT;
          end
        end
        fha_pkg::OP_RESTART: begin
          status_d   = fha_pkg::ST_RESTARTED;
          used_d     = '0;
          internal_d = '0;
          free_d     = loaded_sum_q;
        end
        default: status_d = status_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q   <= fha_pkg::MODE_FIRST;
      loaded_q     <= '0;
      scan_idx_q   <= '0;
      rd_valid_q   <= 1'b0;
      found_q      <= 1'b0;
      used_q       <= '0;
      internal_q   <= '0;
      free_q       <= '0;
      loaded_sum_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      fit_mode_q   <= fit_mode_d;
      loaded_q     <= loaded_d;
      scan_idx_q   <= scan_idx_d;
      rd_valid_q   <= rd_valid_d;
      found_q      <= found_d;
      used_q       <= used_d;
      internal_q   <= internal_d;
      free_q       <= free_d;
      loaded_sum_q <= loaded_sum_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    req_q       <= req_d;
    rd_idx_q    <= rd_idx_d;
    best_idx_q  <= best_idx_d;
    best_size_q <= best_size_d;
    status_q    <= status_d;
    index_q     <= index_d;
    granted_q   <= granted_d;
  end

  // totals only move on commit, which waits for the result word to leave
  assign out_valid_o               = out_valid_q;
  assign out_status_o              = status_q;
  assign out_hole_index_o          = index_q;
  assign out_granted_hole_size_o   = granted_q;
  assign out_internal_frag_total_o = internal_q;
  assign out_external_frag_total_o = free_q;

  assign sts_o.in_op     = in_opcode_i;
  assign sts_o.empty     = (loaded_q == '0);
  assign sts_o.scan_last = (CW'(scan_idx_q) == loaded_q - CW'(1));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

[sim/fit_hole_allocator_test.sv]
// ----------------------------------------------------------------------------
// fit_hole_allocator_test
// self-checking bench for the fit hole allocator: a local copy of the hole
// table, marks and totals predicts every result word, which is compared field
// by field as it leaves the block; both channels stall at random
// ----------------------------------------------------------------------------
module fit_hole_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HOLE_SLOTS = 32;

  // field widths of the block
  localparam int unsigned OP_W    = fha_pkg::OP_W;
  localparam int unsigned SIZE_W  = fha_pkg::SIZE_W;
  localparam int unsigned STAT_W  = fha_pkg::STAT_W;
  localparam int unsigned IDX_W   = fha_pkg::IDX_W;
  localparam int unsigned TOTAL_W = fha_pkg::TOTAL_W;
  localparam int unsigned MODE_W  = fha_pkg::MODE_W;

  // codes the package leaves unnamed
  localparam logic [OP_W-1:0]   OP_UNUSED   = 2'd3;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  // quiet time after the last result, long enough for an allocate over a full table
  localparam int unsigned QUIET_CYCLES = 48;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned PHASE_WORDS  = 125;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [IDX_W-1:0]   slot;
    logic [SIZE_W-1:0]  granted;
    logic [TOTAL_W-1:0] internal_frag;
    logic [TOTAL_W-1:0] external_frag;
  } alloc_result_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [MODE_W-1:0]  cfg_wdata;

  fha_in_if  in_ch ();
  fha_out_if out_ch ();

  fit_hole_allocator #(
    .MAX_HOLES (HOLE_SLOTS)
  ) i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predicted state of the block
  // ---------------------------------------------------------------------------
  logic [SIZE_W-1:0]  model_holes [HOLE_SLOTS];
  bit                 model_used  [HOLE_SLOTS];
  int unsigned        model_count;
  logic [TOTAL_W-1:0] model_internal;
  logic [TOTAL_W-1:0] model_free;
  logic [MODE_W-1:0]  model_mode;

  // result words still owed by the block, oldest first
  alloc_result_t      pending_results [$];

  int unsigned        error_count;
  int unsigned        cycle_count;

  // stall controls, read by the sender task and the ready process
  int unsigned        send_idle_pct;
  int unsigned        recv_idle_pct;
  int unsigned        hold_left;

  // slot the policy picks for a request, -1 when no free hole fits
  function automatic int find_hole(logic [SIZE_W-1:0] req);
    int chosen;
    chosen = -1;
    for (int i = 0; i < model_count; i++) begin
      if (model_used[i]) continue;
      if (model_mode == fha_pkg::MODE_WORST) begin
        // largest free hole, checked against the request only at the end
        if (chosen < 0 || model_holes[i] > model_holes[chosen]) chosen = i;
      end else if (model_holes[i] >= req) begin
        // first fit and the unused mode stop at the lowest fitting slot
        if (model_mode != fha_pkg::MODE_BEST) return i;
        if (chosen < 0 || model_holes[i] < model_holes[chosen]) chosen = i;
      end
    end
    if (chosen >= 0 && model_holes[chosen] < req) chosen = -1;
    return chosen;
  endfunction

  // advance the predicted state by one accepted word and queue its result
  function automatic void apply_word(logic [OP_W-1:0] op, logic [SIZE_W-1:0] size);
    alloc_result_t res;
    int            slot;
    res = '0;
    case (op)
      fha_pkg::OP_LOAD: begin
        if (model_count >= HOLE_SLOTS) begin
          res.status = fha_pkg::ST_FULL;
        end else begin
          res.status = fha_pkg::ST_LOADED;
          res.slot   = model_count[IDX_W-1:0];
          model_holes[model_count] = size;
          model_used[model_count]  = 1'b0;
          model_count++;
          model_free = model_free + TOTAL_W'(size);
        end
      end
      fha_pkg::OP_ALLOC: begin
        slot = find_hole(size);
        if (slot < 0) begin
          res.status = fha_pkg::ST_NO_FIT;
        end else begin
          res.status  = fha_pkg::ST_GRANTED;
          res.slot    = slot[IDX_W-1:0];
          res.granted = model_holes[slot];
          model_used[slot] = 1'b1;
          model_internal = model_internal + TOTAL_W'(model_holes[slot] - size);
          model_free     = model_free - TOTAL_W'(model_holes[slot]);
        end
      end
      fha_pkg::OP_RESTART: begin
        res.status     = fha_pkg::ST_RESTARTED;
        model_internal = '0;
        model_free     = '0;
        for (int i = 0; i < model_count; i++) begin
          model_used[i] = 1'b0;
          model_free    = model_free + TOTAL_W'(model_holes[i]);
        end
      end
      default: return;  // unknown opcode: no result, no change
    endcase
    res.internal_frag = model_internal;
    res.external_frag = model_free;
    pending_results.push_back(res);
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    error_count++;
    $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
  endtask

  // result words are sampled at the rising edge, before the block updates
  always @(posedge clk) begin
    alloc_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result word, status", out_ch.status, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.status !== want.status)
          report_mismatch("status", out_ch.status, want.status);
        if (out_ch.hole_index !== want.slot)
          report_mismatch("hole_index", out_ch.hole_index, want.slot);
        if (out_ch.granted_hole_size !== want.granted)
          report_mismatch("granted_hole_size", out_ch.granted_hole_size, want.granted);
        if (out_ch.internal_frag_total !== want.internal_frag)
          report_mismatch("internal_frag_total", out_ch.internal_frag_total,
                          want.internal_frag);
        if (out_ch.external_frag_total !== want.external_frag)
          report_mismatch("external_frag_total", out_ch.external_frag_total,
                          want.external_frag);
      end
    end
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: a long hold-off when asked, else random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers, all entered and left just after a falling edge
  // ---------------------------------------------------------------------------
  function automatic void set_profile(int unsigned send_pct, int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endfunction

  // offer one word, hold it until the block takes it, then predict
  task automatic send_word(logic [OP_W-1:0] op, logic [SIZE_W-1:0] size);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    // valid stays high across back-to-back words, never dropped and raised
    in_ch.valid     <= 1'b1;
    in_ch.opcode    <= op;
    in_ch.item_size <= size;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    apply_word(op, size);
    @(negedge clk);
  endtask

  // stop sending and wait until every owed word is back and the block is quiet
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  // the mode register is only touched while the block is idle
  task automatic write_fit_mode(logic [MODE_W-1:0] mode);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(negedge clk);
    cfg_we     <= 1'b0;
    model_mode  = mode;
  endtask

  // request size near some loaded hole, plus extremes and pure noise
  function automatic logic [SIZE_W-1:0] pick_request();
    int unsigned       dice;
    logic [SIZE_W-1:0] hole;
    dice = $urandom_range(99);
    if (model_count == 0) hole = SIZE_W'($urandom());
    else hole = model_holes[$urandom_range(model_count - 1)];
    if (dice < 25) return hole;
    if (dice < 40) return hole - SIZE_W'($urandom_range(hole < 3 ? hole : 3));
    if (dice < 50) return (hole == '1) ? hole : hole + 1'b1;
    if (dice < 65) return SIZE_W'($urandom_range(hole));
    if (dice < 72) return '0;
    if (dice < 78) return '1;
    return SIZE_W'($urandom());
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // allocate and restart with nothing loaded, plus an ignored opcode
  task automatic test_empty_table();
    send_word(fha_pkg::OP_ALLOC, 16'd0);
    send_word(fha_pkg::OP_ALLOC, 16'hFFFF);
    send_word(fha_pkg::OP_RESTART, 16'd0);
    send_word(OP_UNUSED, 16'hFFFF);
  endtask

  // zero-size hole, zero request, duplicate sizes and the largest size
  task automatic test_first_fit();
    send_word(fha_pkg::OP_LOAD, 16'd0);
    send_word(fha_pkg::OP_ALLOC, 16'd0);      // zero request fits the zero hole
    send_word(fha_pkg::OP_ALLOC, 16'd0);      // nothing free left
    send_word(fha_pkg::OP_LOAD, 16'hFFFF);
    send_word(fha_pkg::OP_LOAD, 16'd100);
    send_word(fha_pkg::OP_LOAD, 16'd100);
    send_word(fha_pkg::OP_LOAD, 16'hFFFF);
    send_word(fha_pkg::OP_LOAD, 16'd5000);
    send_word(fha_pkg::OP_ALLOC, 16'd101);    // lowest fitting slot, not the closest
    send_word(fha_pkg::OP_ALLOC, 16'd100);
    send_word(fha_pkg::OP_RESTART, 16'hFFFF);
  endtask

  // smallest fitting hole, ties to the lower slot
  task automatic test_best_fit();
    write_fit_mode(fha_pkg::MODE_BEST);
    send_word(fha_pkg::OP_ALLOC, 16'd100);
    send_word(fha_pkg::OP_ALLOC, 16'd50);
    send_word(fha_pkg::OP_ALLOC, 16'd0);
    send_word(fha_pkg::OP_ALLOC, 16'd5001);   // two equal largest holes
    send_word(fha_pkg::OP_ALLOC, 16'hFFFF);
    send_word(fha_pkg::OP_RESTART, 16'd0);
  endtask

  // largest free hole, refused when even that one is too small
  task automatic test_worst_fit();
    write_fit_mode(fha_pkg::MODE_WORST);
    send_word(fha_pkg::OP_ALLOC, 16'd1);
    send_word(fha_pkg::OP_ALLOC, 16'hFFFF);
    send_word(fha_pkg::OP_ALLOC, 16'd5001);
    send_word(fha_pkg::OP_ALLOC, 16'd5000);
    send_word(fha_pkg::OP_RESTART, 16'd0);
  endtask

  // the spare mode code behaves as first fit
  task automatic test_unknown_mode();
    write_fit_mode(MODE_UNUSED);
    send_word(fha_pkg::OP_ALLOC, 16'd50);
    send_word(fha_pkg::OP_RESTART, 16'd0);
    write_fit_mode(fha_pkg::MODE_FIRST);
  endtask

  // fill every slot, then loads past the end are refused
  task automatic test_table_full();
    int unsigned       dice;
    logic [SIZE_W-1:0] size;
    while (model_count < HOLE_SLOTS) begin
      dice = $urandom_range(99);
      if (dice < 20) size = model_holes[$urandom_range(model_count - 1)];
      else if (dice < 30) size = SIZE_W'($urandom_range(15));
      else size = SIZE_W'($urandom());
      send_word(fha_pkg::OP_LOAD, size);
    end
    repeat (3) send_word(fha_pkg::OP_LOAD, SIZE_W'($urandom()));
    send_word(fha_pkg::OP_RESTART, 16'd0);
    send_word(fha_pkg::OP_ALLOC, 16'd0);
  endtask

  // receiver holds off long enough that the block stops taking words
  task automatic test_backpressure();
    set_profile(0, 0);
    @(posedge clk);
    hold_left = 400;
    @(negedge clk);
    send_word(fha_pkg::OP_RESTART, 16'd0);
    repeat (24) send_word(fha_pkg::OP_ALLOC, pick_request());
    drain_results();
  endtask

  // sender stops until everything owed has come back, then carries on
  task automatic test_sender_pause();
    set_profile(16, 84);
    send_word(fha_pkg::OP_RESTART, 16'd0);
    repeat (6) send_word(fha_pkg::OP_ALLOC, pick_request());
    drain_results();
    repeat (6) send_word(fha_pkg::OP_ALLOC, pick_request());
    drain_results();
  endtask

  // mostly restart-then-allocate runs, some stray words of any opcode
  task automatic run_random_phase(int unsigned word_goal);
    int unsigned     sent;
    int unsigned     run_len;
    logic [OP_W-1:0] op;
    sent = 0;
    while (sent < word_goal) begin
      if ($urandom_range(99) < 85) begin
        send_word(fha_pkg::OP_RESTART, SIZE_W'($urandom()));
        sent++;
        // runs longer than the table also hit the all-used case
        run_len = $urandom_range(1, 36);
        repeat (run_len) begin
          send_word(fha_pkg::OP_ALLOC, pick_request());
          sent++;
        end
      end else begin
        op = OP_W'($urandom_range(3));
        send_word(op, SIZE_W'($urandom()));
        if (op != OP_UNUSED) sent++;
      end
    end
  endtask

  // every stall profile under every mode code, extremes included
  task automatic test_random_mix();
    logic [MODE_W-1:0] modes [4];
    modes = '{fha_pkg::MODE_FIRST, fha_pkg::MODE_BEST, fha_pkg::MODE_WORST,
              MODE_UNUSED};
    for (int prof = 0; prof < 3; prof++) begin
      case (prof)
        0:       set_profile(16, 84);
        1:       set_profile(84, 16);
        default: set_profile(0, 0);
      endcase
      foreach (modes[m]) begin
        write_fit_mode(modes[m]);
        run_random_phase(PHASE_WORDS);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = fha_pkg::MODE_FIRST;
    in_ch.valid     = 1'b0;
    in_ch.opcode    = fha_pkg::OP_LOAD;
    in_ch.item_size = '0;
    out_ch.ready    = 1'b0;
    hold_left       = 0;
    error_count     = 0;
    cycle_count     = 0;
    model_count     = 0;
    model_internal  = '0;
    model_free      = '0;
    model_mode      = fha_pkg::MODE_FIRST;
    foreach (model_used[i]) model_used[i] = 1'b0;
    set_profile(16, 84);

    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    write_fit_mode(fha_pkg::MODE_FIRST);
    test_empty_table();
    test_first_fit();
    test_best_fit();
    test_worst_fit();
    test_unknown_mode();
    test_table_full();
    test_backpressure();
    test_sender_pause();
    test_random_mix();
    drain_results();

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/fha_pkg.sv
rtl/fha_if.sv
rtl/fha_ram.sv
rtl/fha_ctrl.sv
rtl/fha_datapath.sv
rtl/fit_hole_allocator.sv
sim/fit_hole_allocator_test.sv
